FILE: rtl/ragmt_pkg.sv
// Package for the range-add / global-maximum segment tree block.
// Holds the sequencer state type, opcodes, field widths and the node RAM write type.
// Depends on nothing; every other file in rtl/ imports it.
package ragmt_pkg;

   localparam int DATA_W  = 48;
   localparam int DELTA_W = 32;
   localparam int START_W = 10;
   localparam int END_W   = 11;

   localparam logic OP_SET = 1'b0;
   localparam logic OP_ADD = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOP,
      ST_L_RD,
      ST_L_WR,
      ST_R_RD,
      ST_R_WR,
      ST_PULL_A,
      ST_PULL_B,
      ST_PULL_W,
      ST_ROOT_RD,
      ST_ROOT_SUM
   } state_type;

   // One write port command for the node RAM: the max half and the addend half
   // of a node are enabled separately.
   typedef struct packed {
      logic              max_en;
      logic              add_en;
      logic [DATA_W-1:0] max_data;
      logic [DATA_W-1:0] add_data;
   } ram_wr_type;

endpackage

FILE: rtl/ragmt_node_ram.sv
// Node storage of the segment tree: per-node subtree maximum and pending addend.
// One write port with separate enables per half, one registered read port.
// Depends on ragmt_pkg.
module ragmt_node_ram #(
   parameter int ADDR_W = 11
) (
   input  logic                           clock,
   input  logic [ADDR_W-1:0]              rd_addr,
   output logic [ragmt_pkg::DATA_W-1:0]   rd_max,
   output logic [ragmt_pkg::DATA_W-1:0]   rd_add,
   input  logic [ADDR_W-1:0]              wr_addr,
   input  ragmt_pkg::ram_wr_type          wr
);
   import ragmt_pkg::*;

   localparam int DEPTH = 2 ** ADDR_W;

   logic [DATA_W-1:0] max_mem [DEPTH];
   logic [DATA_W-1:0] add_mem [DEPTH];
   logic [DATA_W-1:0] rd_max_ff;
   logic [DATA_W-1:0] rd_add_ff;

   always_ff @(posedge clock) begin
      if (wr.max_en) begin
         max_mem[wr_addr] <= wr.max_data;
      end
      if (wr.add_en) begin
         add_mem[wr_addr] <= wr.add_data;
      end
      rd_max_ff <= max_mem[rd_addr];
      rd_add_ff <= add_mem[rd_addr];
   end

   assign rd_max = rd_max_ff;
   assign rd_add = rd_add_ff;

endmodule

FILE: rtl/ragmt_alu.sv
// Shared arithmetic unit of the tree sequencer: one 48-bit wrapping adder
// followed by a signed compare of the sum against a held value.
// Depends on ragmt_pkg.
module ragmt_alu (
   input  logic [ragmt_pkg::DATA_W-1:0] op_a,
   input  logic [ragmt_pkg::DATA_W-1:0] op_b,
   input  logic [ragmt_pkg::DATA_W-1:0] ref_val,
   output logic [ragmt_pkg::DATA_W-1:0] sum,
   output logic                         sum_gt
);
   import ragmt_pkg::*;

   assign sum    = op_a + op_b;
   assign sum_gt = $signed(sum) > $signed(ref_val);

endmodule

FILE: rtl/range_add_global_max_tree_top.sv
// Range-add / global-maximum segment tree over LEAF_COUNT leaves.
// Every req_ transaction either sets one leaf (opcode OP_SET: leaf range_start
// takes the sign-extended delta and its own addend is cleared) or adds delta to
// every leaf in [range_start, range_end) (opcode OP_ADD, range_end clamped to
// LEAF_COUNT; an empty range or an out-of-range leaf changes nothing).
// Each transaction returns exactly one rsp_ transaction carrying the maximum
// over all leaves afterwards, as 48-bit wrapping two's complement.
// The tree is bottom-up with no push-down; node maxima and addends live in one
// RAM with a single registered read port, and one shared adder/comparator does
// all arithmetic, so the block works on one transaction at a time.
// With L = log2 of the leaf count rounded up to a power of two: a set writes
// the leaf, then climbs its ancestors (reading both children and writing the
// parent at each level) and reads the root; a range add walks the range
// boundaries, then climbs from the first and from the last leaf, then reads the root.
// The RAM read port bounds every step. req_ready is high only while idle.
// The result sits in an output register: the block accepts the next request
// while an earlier result still waits, and stalls only before writing a new
// result into an occupied output register.
// After reset the block sweeps all 2 * 2**L nodes to zero, one node a
// cycle (2048 nodes at the default size), with req_ready low meanwhile.
module range_add_global_max_tree_top #(
   parameter int LEAF_COUNT = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_opcode,
   input  logic [ragmt_pkg::START_W-1:0]       req_range_start,
   input  logic [ragmt_pkg::END_W-1:0]         req_range_end,
   input  logic signed [ragmt_pkg::DELTA_W-1:0] req_delta,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [ragmt_pkg::DATA_W-1:0] rsp_global_max
);
   import ragmt_pkg::*;

   localparam int LOG_TL      = $clog2(LEAF_COUNT);
   localparam int TREE_LEAVES = 2 ** LOG_TL;
   localparam int NODE_COUNT  = 2 * TREE_LEAVES;
   localparam int NODE_W      = LOG_TL + 1;
   localparam int PTR_W       = NODE_W + 1;
   localparam int LC_W        = $clog2(LEAF_COUNT + 1);
   localparam int CMP_W       = (LC_W > END_W) ? LC_W : END_W;

   localparam logic [CMP_W-1:0]  LC_X       = CMP_W'(LEAF_COUNT);
   localparam logic [PTR_W-1:0]  TL_P       = PTR_W'(TREE_LEAVES);
   localparam logic [PTR_W-1:0]  LIVE_END0  = PTR_W'(TREE_LEAVES + LEAF_COUNT);
   localparam logic [NODE_W-1:0] CLEAR_LAST = NODE_W'(NODE_COUNT - 1);
   localparam logic [NODE_W-1:0] ROOT_ADDR  = NODE_W'(1);

   state_type state_ff, state_in;

   logic [NODE_W-1:0]   clr_cnt_ff, clr_cnt_in;
   logic [PTR_W-1:0]    l_ff, l_in;
   logic [PTR_W-1:0]    r_ff, r_in;
   logic [NODE_W-2:0]   node_ff, node_in;
   logic [NODE_W-2:0]   pend_node_ff, pend_node_in;
   logic                pend_valid_ff, pend_valid_in;
   logic [PTR_W-1:0]    live_end_ff, live_end_in;
   logic [DATA_W-1:0]   d_ff, d_in;
   logic [DATA_W-1:0]   best_ff, best_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_max_ff, rsp_max_in;

   logic [NODE_W-1:0]   rd_addr;
   logic [NODE_W-1:0]   wr_addr;
   ram_wr_type          ram_wr;
   logic [DATA_W-1:0]   rd_max;
   logic [DATA_W-1:0]   rd_add;

   logic [DATA_W-1:0]   alu_a;
   logic [DATA_W-1:0]   alu_b;
   logic [DATA_W-1:0]   alu_sum;
   logic                alu_gt;

   logic [CMP_W-1:0]    start_x;
   logic [CMP_W-1:0]    end_x;
   logic [CMP_W-1:0]    end_c;
   logic                set_ok;
   logic                add_ok;
   logic [PTR_W-1:0]    first_leaf;
   logic [PTR_W-1:0]    end_leaf;
   logic [PTR_W-1:0]    last_leaf;
   logic [PTR_W-1:0]    r_m1;
   logic [PTR_W-1:0]    l_p1;
   logic                req_fire;
   logic                l_lt_r;
   logic                node_zero;
   logic                right_live;
   logic                slot_free;

   ragmt_node_ram #(
      .ADDR_W (NODE_W)
   ) u_node_ram (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_max  (rd_max),
      .rd_add  (rd_add),
      .wr_addr (wr_addr),
      .wr      (ram_wr)
   );

   ragmt_alu u_alu (
      .op_a    (alu_a),
      .op_b    (alu_b),
      .ref_val (best_ff),
      .sum     (alu_sum),
      .sum_gt  (alu_gt)
   );

   // Request decode. The range end is clamped to the leaf count before use.
   assign start_x    = CMP_W'(req_range_start);
   assign end_x      = CMP_W'(req_range_end);
   assign end_c      = (end_x > LC_X) ? LC_X : end_x;
   assign set_ok     = start_x < LC_X;
   assign add_ok     = start_x < end_c;
   assign first_leaf = TL_P + PTR_W'(start_x);
   assign end_leaf   = TL_P + PTR_W'(end_c);
   assign last_leaf  = end_leaf - PTR_W'(1);

   assign req_fire   = req_valid && (state_ff == ST_IDLE);
   assign l_lt_r     = l_ff < r_ff;
   assign r_m1       = r_ff - PTR_W'(1);
   assign l_p1       = l_ff + PTR_W'(1);
   assign node_zero  = (node_ff == '0);
   // The right child counts only if it covers at least one real leaf; every
   // node index below live_end_ff at the child level does.
   assign right_live = PTR_W'({node_ff, 1'b1}) < live_end_ff;
   assign slot_free  = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == CLEAR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_opcode == OP_SET) begin
                  state_in = set_ok ? ST_PULL_A : ST_ROOT_RD;
               end else begin
                  state_in = add_ok ? ST_LOOP : ST_ROOT_RD;
               end
            end
         end
         ST_LOOP: begin
            priority if (!l_lt_r) begin
               state_in = ST_PULL_A;
            end else if (l_ff[0]) begin
               state_in = ST_L_RD;
            end else if (r_ff[0]) begin
               state_in = ST_R_RD;
            end else begin
               state_in = ST_LOOP;
            end
         end
         ST_L_RD:   state_in = ST_L_WR;
         ST_L_WR:   state_in = r_ff[0] ? ST_R_RD : ST_LOOP;
         ST_R_RD:   state_in = ST_R_WR;
         ST_R_WR:   state_in = ST_LOOP;
         ST_PULL_A: begin
            priority if (!node_zero) begin
               state_in = ST_PULL_B;
            end else if (pend_valid_ff) begin
               state_in = ST_PULL_A;
            end else begin
               state_in = ST_ROOT_RD;
            end
         end
         ST_PULL_B:   state_in = ST_PULL_W;
         ST_PULL_W:   state_in = ST_PULL_A;
         ST_ROOT_RD:  state_in = ST_ROOT_SUM;
         ST_ROOT_SUM: state_in = slot_free ? ST_IDLE : ST_ROOT_SUM;
         default:     state_in = ST_CLEAR;
      endcase
   end

   // Datapath control, RAM and shared-unit operands.
   always_comb begin
      clr_cnt_in    = clr_cnt_ff;
      l_in          = l_ff;
      r_in          = r_ff;
      node_in       = node_ff;
      pend_node_in  = pend_node_ff;
      pend_valid_in = pend_valid_ff;
      live_end_in   = live_end_ff;
      d_in          = d_ff;
      best_in       = best_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_max_in    = rsp_max_ff;
      rd_addr       = '0;
      wr_addr       = '0;
      ram_wr        = '0;
      alu_a         = rd_max;
      alu_b         = rd_add;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_addr       = clr_cnt_ff;
            ram_wr.max_en = 1'b1;
            ram_wr.add_en = 1'b1;
            clr_cnt_in    = clr_cnt_ff + NODE_W'(1);
         end
         ST_IDLE: begin
            if (req_fire) begin
               d_in          = {{(DATA_W - DELTA_W){req_delta[DELTA_W-1]}}, req_delta};
               l_in          = first_leaf;
               r_in          = end_leaf;
               node_in       = first_leaf[NODE_W-1:1];
               pend_node_in  = last_leaf[NODE_W-1:1];
               pend_valid_in = (req_opcode == OP_ADD);
               live_end_in   = LIVE_END0;
               // A set writes the leaf right away and then climbs its ancestors.
               if ((req_opcode == OP_SET) && set_ok) begin
                  wr_addr         = first_leaf[NODE_W-1:0];
                  ram_wr.max_en   = 1'b1;
                  ram_wr.add_en   = 1'b1;
                  ram_wr.max_data = {{(DATA_W - DELTA_W){req_delta[DELTA_W-1]}}, req_delta};
                  ram_wr.add_data = '0;
               end
            end
         end
         ST_LOOP: begin
            if (l_lt_r && !l_ff[0] && !r_ff[0]) begin
               l_in = l_ff >> 1;
               r_in = r_ff >> 1;
            end
         end
         ST_L_RD: begin
            rd_addr = l_ff[NODE_W-1:0];
         end
         ST_L_WR: begin
            alu_a           = rd_add;
            alu_b           = d_ff;
            wr_addr         = l_ff[NODE_W-1:0];
            ram_wr.add_en   = 1'b1;
            ram_wr.add_data = alu_sum;
            if (r_ff[0]) begin
               l_in = l_p1;
            end else begin
               l_in = l_p1 >> 1;
               r_in = r_ff >> 1;
            end
         end
         ST_R_RD: begin
            rd_addr = r_m1[NODE_W-1:0];
            r_in    = r_m1;
         end
         ST_R_WR: begin
            alu_a           = rd_add;
            alu_b           = d_ff;
            wr_addr         = r_ff[NODE_W-1:0];
            ram_wr.add_en   = 1'b1;
            ram_wr.add_data = alu_sum;
            l_in            = l_ff >> 1;
            r_in            = r_ff >> 1;
         end
         ST_PULL_A: begin
            if (!node_zero) begin
               rd_addr = {node_ff, 1'b0};
            end else if (pend_valid_ff) begin
               // First climb done; start the climb from the last leaf.
               node_in       = pend_node_ff;
               pend_valid_in = 1'b0;
               live_end_in   = LIVE_END0;
            end
         end
         ST_PULL_B: begin
            rd_addr = {node_ff, 1'b1};
            best_in = alu_sum;
         end
         ST_PULL_W: begin
            wr_addr         = NODE_W'(node_ff);
            ram_wr.max_en   = 1'b1;
            ram_wr.max_data = (right_live && alu_gt) ? alu_sum : best_ff;
            node_in         = node_ff >> 1;
            live_end_in     = (live_end_ff + PTR_W'(1)) >> 1;
         end
         ST_ROOT_RD: begin
            rd_addr = ROOT_ADDR;
         end
         ST_ROOT_SUM: begin
            rd_addr = ROOT_ADDR;
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_max_in   = alu_sum;
            end
         end
         default: begin
            clr_cnt_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      l_ff         <= l_in;
      r_ff         <= r_in;
      node_ff      <= node_in;
      pend_node_ff <= pend_node_in;
      live_end_ff  <= live_end_in;
      d_ff         <= d_in;
      best_ff      <= best_in;
      rsp_max_ff   <= rsp_max_in;
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_global_max = rsp_max_ff;

endmodule
